/* rtl/core/mmss_pkg.sv */
// Shared types and constants for the mm:ss countdown timer with alarm.
package mmss_pkg;

    localparam int MAX_SECONDS      = 5999;
    localparam int RING_EVERY_TICKS = 5;
    localparam int SEC_PER_MIN      = 60;
    localparam int SEC_REPEAT_STEP  = 5;
    localparam int MS_PER_S         = 1000;
    localparam int MS_ROUND         = MS_PER_S - 1;

    localparam int SEC_W    = 13;
    localparam int MS_W     = 23;
    localparam int ELAPSED_W = 10;
    localparam int ALARM_W  = 8;
    localparam int MIN_W    = 7;
    localparam int SS_W     = 6;

    // reciprocal constants for divide-by-constant
    localparam int    DIV_MS_SHIFT  = 33;
    localparam longint DIV_MS_RECIP =
        ((longint'(1) << DIV_MS_SHIFT) + MS_PER_S - 1) / MS_PER_S;
    localparam int    DIV_MIN_SHIFT = 19;
    localparam int    DIV_MIN_RECIP =
        ((1 << DIV_MIN_SHIFT) + SEC_PER_MIN - 1) / SEC_PER_MIN;
    localparam int    RING_SHIFT    = 12;
    localparam int    RING_RECIP    =
        ((1 << RING_SHIFT) + RING_EVERY_TICKS - 1) / RING_EVERY_TICKS;

    typedef enum logic [1:0] {
        MODE_SETUP = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PAUSE = 2'd2,
        MODE_ALARM = 2'd3
    } mode_t;

    localparam logic [2:0] KEY_UP    = 3'd0;
    localparam logic [2:0] KEY_DOWN  = 3'd1;
    localparam logic [2:0] KEY_LEFT  = 3'd2;
    localparam logic [2:0] KEY_RIGHT = 3'd3;
    localparam logic [2:0] KEY_OK    = 3'd4;
    localparam logic [2:0] KEY_BACK  = 3'd5;

    localparam logic [1:0] KIND_SHORT  = 2'd0;
    localparam logic [1:0] KIND_REPEAT = 2'd1;

    localparam logic FIELD_MIN = 1'b0;
    localparam logic FIELD_SEC = 1'b1;

    localparam logic IN_TICK = 1'b0;

    typedef struct packed {
        mode_t             timer_mode;
        logic              edit_field;
        logic [SEC_W-1:0]  preset;
        logic [MS_W-1:0]   ms;
        logic              ring;
        logic              silence;
        logic              blink;
    } res_t;

endpackage

/* rtl/core/mm_ss_countdown_timer_with_alarm_unit.sv */
// Top level of the mm:ss countdown timer with alarm.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | mode, key, press_kind, elapsed_ms
//  out      | out_valid / out_ready | timer_mode ... blink_on (one per request)
//  cfg      | cfg_valid / cfg_ready | initial_preset_seconds
//
// One request per cycle while the output is not stalled; each accepted request
// passes through input reg, state update, ms-to-seconds, seconds-to-minutes, output.
// The whole pipeline advances together whenever the output register is empty
// or being taken; a stalled output holds every stage and in_ready drops.
// rst_n clears all valid bits and the timer state; cfg_ready is always high.
module mm_ss_countdown_timer_with_alarm_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic [2:0]                 key,
    input  logic [1:0]                 press_kind,
    input  logic [mmss_pkg::ELAPSED_W-1:0] elapsed_ms,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 timer_mode,
    output logic                       edit_field,
    output logic [mmss_pkg::MIN_W-1:0] shown_minutes,
    output logic [mmss_pkg::SS_W-1:0]  shown_seconds,
    output logic [mmss_pkg::SEC_W-1:0] preset_seconds_out,
    output logic [mmss_pkg::MS_W-1:0]  time_left_ms,
    output logic                       ring,
    output logic                       silence,
    output logic                       blink_on,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mmss_pkg::SEC_W-1:0] initial_preset_seconds
);
    import mmss_pkg::*;

    logic en;
    logic res_valid;
    res_t res;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    mmss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .mode       (mode),
        .key        (key),
        .press_kind (press_kind),
        .elapsed_ms (elapsed_ms),
        .cfg_we     (cfg_valid),
        .cfg_value  (initial_preset_seconds),
        .res_valid  (res_valid),
        .res        (res)
    );

    mmss_disp u_disp (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .res_valid          (res_valid),
        .res                (res),
        .out_valid          (out_valid),
        .timer_mode         (timer_mode),
        .edit_field         (edit_field),
        .shown_minutes      (shown_minutes),
        .shown_seconds      (shown_seconds),
        .preset_seconds_out (preset_seconds_out),
        .time_left_ms       (time_left_ms),
        .ring               (ring),
        .silence            (silence),
        .blink_on           (blink_on)
    );

endmodule

/* rtl/core/mmss_ctrl.sv */
// Input register, timer state update and first result register.
module mmss_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic                      mode,
    input  logic [2:0]                key,
    input  logic [1:0]                press_kind,
    input  logic [mmss_pkg::ELAPSED_W-1:0] elapsed_ms,
    input  logic                      cfg_we,
    input  logic [mmss_pkg::SEC_W-1:0] cfg_value,
    output logic                      res_valid,
    output mmss_pkg::res_t            res
);
    import mmss_pkg::*;

    function automatic logic [SEC_W-1:0] clamp_preset(input logic [SEC_W:0] v);
        return (v > (SEC_W+1)'(MAX_SECONDS)) ? SEC_W'(MAX_SECONDS) : v[SEC_W-1:0];
    endfunction

    logic                 in_vld_reg;
    logic                 in_mode_reg;
    logic [2:0]           in_key_reg;
    logic [1:0]           in_kind_reg;
    logic [ELAPSED_W-1:0] in_elapsed_reg;

    mode_t                mode_reg, mode_next;
    logic                 field_reg, field_next;
    logic [SEC_W-1:0]     preset_reg, preset_next;
    logic [MS_W-1:0]      rem_reg, rem_next;
    logic [ALARM_W-1:0]   alarm_cnt_reg, alarm_cnt_next;

    logic                 res_vld_reg;
    res_t                 res_reg, res_next;

    logic                 ring, silence;
    logic                 key_ok, kind_short;
    logic [SEC_W-1:0]     step;
    logic [SEC_W-1:0]     preset_up, preset_dn;
    logic [MS_W-1:0]      rem_sat;
    logic [20:0]          ring_prod;
    logic [ALARM_W-1:0]   ring_q, ring_rem;
    logic                 update;

    assign update = en && in_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_mode_reg    <= mode;
            in_key_reg     <= key;
            in_kind_reg    <= press_kind;
            in_elapsed_reg <= elapsed_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SETUP;
            field_reg     <= FIELD_MIN;
            preset_reg    <= '0;
            rem_reg       <= '0;
            alarm_cnt_reg <= '0;
        end
        else if (cfg_we)
        begin
            preset_reg <= clamp_preset({1'b0, cfg_value});
        end
        else if (update)
        begin
            mode_reg      <= mode_next;
            field_reg     <= field_next;
            preset_reg    <= preset_next;
            rem_reg       <= rem_next;
            alarm_cnt_reg <= alarm_cnt_next;
        end
    end

    // alarm_count mod RING_EVERY_TICKS
    assign ring_prod = 21'(alarm_cnt_reg) * 21'(RING_RECIP);
    assign ring_q    = ALARM_W'(ring_prod >> RING_SHIFT);
    assign ring_rem  = alarm_cnt_reg - ALARM_W'(13'(ring_q) * 13'(RING_EVERY_TICKS));

    assign key_ok     = (in_key_reg < KEY_BACK) && (in_kind_reg <= KIND_REPEAT);
    assign kind_short = (in_kind_reg == KIND_SHORT);

    always_comb
    begin
        if (field_reg == FIELD_MIN)
            step = SEC_W'(SEC_PER_MIN);
        else if (kind_short)
            step = SEC_W'(1);
        else
            step = SEC_W'(SEC_REPEAT_STEP);
    end

    assign preset_up = clamp_preset({1'b0, preset_reg} + {1'b0, step});
    assign preset_dn = (preset_reg > step) ? preset_reg - step : '0;
    assign rem_sat   = (rem_reg > MS_W'(in_elapsed_reg)) ?
                       rem_reg - MS_W'(in_elapsed_reg) : '0;

    always_comb
    begin
        mode_next      = mode_reg;
        field_next     = field_reg;
        preset_next    = preset_reg;
        rem_next       = rem_reg;
        alarm_cnt_next = alarm_cnt_reg;
        ring           = 1'b0;
        silence        = 1'b0;
        if (in_mode_reg == IN_TICK)
        begin
            unique case (mode_reg)
                MODE_RUN:
                begin
                    rem_next = rem_sat;
                    if (rem_sat == '0)
                    begin
                        mode_next      = MODE_ALARM;
                        ring           = 1'b1;
                        alarm_cnt_next = ALARM_W'(1);
                    end
                end
                MODE_ALARM:
                begin
                    ring           = (ring_rem == '0);
                    alarm_cnt_next = alarm_cnt_reg + ALARM_W'(1);
                end
                default:
                begin
                end
            endcase
        end
        else if (key_ok)
        begin
            unique case (mode_reg)
                MODE_SETUP:
                begin
                    if (in_key_reg == KEY_LEFT || in_key_reg == KEY_RIGHT)
                    begin
                        if (kind_short)
                            field_next = ~field_reg;
                    end
                    else if (in_key_reg == KEY_UP)
                        preset_next = preset_up;
                    else if (in_key_reg == KEY_DOWN)
                        preset_next = preset_dn;
                    else if (kind_short && preset_reg != '0)
                    begin
                        rem_next  = MS_W'(preset_reg) * MS_W'(MS_PER_S);
                        mode_next = MODE_RUN;
                    end
                end
                MODE_RUN, MODE_PAUSE:
                begin
                    if (in_key_reg == KEY_OK && kind_short)
                        mode_next = (mode_reg == MODE_RUN) ? MODE_PAUSE : MODE_RUN;
                    else if (in_key_reg == KEY_LEFT && kind_short)
                        mode_next = MODE_SETUP;
                end
                MODE_ALARM:
                begin
                    mode_next = MODE_SETUP;
                    silence   = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.timer_mode = mode_next;
        res_next.edit_field = field_next;
        res_next.preset     = preset_next;
        res_next.ring       = ring;
        res_next.silence    = silence;
        res_next.blink      = (mode_next == MODE_ALARM) && alarm_cnt_next[0];
        case (mode_next)
            MODE_SETUP: res_next.ms = MS_W'(preset_next) * MS_W'(MS_PER_S);
            MODE_ALARM: res_next.ms = '0;
            default:    res_next.ms = rem_next;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            res_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

/* rtl/core/mmss_disp.sv */
// Display conversion: ms rounded up to seconds, then split into mm:ss.
module mmss_disp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       res_valid,
    input  mmss_pkg::res_t             res,
    output logic                       out_valid,
    output logic [1:0]                 timer_mode,
    output logic                       edit_field,
    output logic [mmss_pkg::MIN_W-1:0] shown_minutes,
    output logic [mmss_pkg::SS_W-1:0]  shown_seconds,
    output logic [mmss_pkg::SEC_W-1:0] preset_seconds_out,
    output logic [mmss_pkg::MS_W-1:0]  time_left_ms,
    output logic                       ring,
    output logic                       silence,
    output logic                       blink_on
);
    import mmss_pkg::*;

    logic             s2_vld_reg, s3_vld_reg, out_vld_reg;
    res_t             s2_res_reg, s3_res_reg, out_res_reg;
    logic [SEC_W-1:0] s2_total_reg, s3_total_reg;
    logic [MIN_W-1:0] s3_min_reg, out_min_reg;
    logic [SS_W-1:0]  out_sec_reg;

    logic [MS_W:0]    ms_up;
    logic [47:0]      ms_prod;
    logic [31:0]      min_prod;
    logic [SEC_W-1:0] sec_rem;

    assign ms_up    = {1'b0, res.ms} + (MS_W+1)'(MS_ROUND);
    assign ms_prod  = 48'(ms_up) * 48'(DIV_MS_RECIP);
    assign min_prod = 32'(s2_total_reg) * 32'(DIV_MIN_RECIP);
    assign sec_rem  = s3_total_reg - SEC_W'(SEC_W'(s3_min_reg) * SEC_W'(SEC_PER_MIN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg  <= res_valid;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_res_reg   <= res;
            s2_total_reg <= SEC_W'(ms_prod >> DIV_MS_SHIFT);
            s3_res_reg   <= s2_res_reg;
            s3_total_reg <= s2_total_reg;
            s3_min_reg   <= MIN_W'(min_prod >> DIV_MIN_SHIFT);
            out_res_reg  <= s3_res_reg;
            out_min_reg  <= s3_min_reg;
            out_sec_reg  <= SS_W'(sec_rem);
        end
    end

    assign out_valid          = out_vld_reg;
    assign timer_mode         = out_res_reg.timer_mode;
    assign edit_field         = out_res_reg.edit_field;
    assign shown_minutes      = out_min_reg;
    assign shown_seconds      = out_sec_reg;
    assign preset_seconds_out = out_res_reg.preset;
    assign time_left_ms       = out_res_reg.ms;
    assign ring               = out_res_reg.ring;
    assign silence            = out_res_reg.silence;
    assign blink_on           = out_res_reg.blink;

endmodule
